FILE: rtl/core/glp_pkg.sv
// Shared types and constants for the glyph line packer.
// Used by glyph_line_packer; no dependencies.
package glp_pkg;

  // Default store depth and register reset values.
  localparam int MAX_LETTERS_DEF = 32;
  localparam logic [19:0] LINE_LIMIT_RESET = 20'd1000000;
  localparam logic [3:0]  MIP_LEVELS_RESET = 4'd0;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIP_LEVELS = 2'd0;
  localparam logic [1:0] CFG_LINE_LIMIT = 2'd1;

  // Input commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Input item.
  typedef struct packed {
    logic        command;
    logic [15:0] glyph_width;
    logic        last;
  } glp_in_t;

  // Result item.
  typedef struct packed {
    logic        is_summary;
    logic [4:0]  glyph_index;
    logic [4:0]  line_index;
    logic [5:0]  line_count;
    logic [19:0] max_line_width;
    logic        overflow;
    logic        last_result;
  } glp_out_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RANK_A,
    S_RANK_B,
    S_RANK_SCAN,
    S_LINES,
    S_INIT,
    S_PICK_A,
    S_PICK_B,
    S_PICK_C,
    S_SCAN,
    S_UPD,
    S_CHECK,
    S_EMIT,
    S_SUM
  } glp_state_t;

endpackage

FILE: rtl/core/glyph_line_packer.sv
// Glyph line packer top level: load store, sort, line packing and result sequencer.
// Depends on glp_pkg and glp_ram.
//
// Usage: an item is taken when start is high and busy is low. A load item
// (command 0) writes one glyph width into the width memory, so
// items stream at one per cycle while loading. A clear item empties the set.
// A load item with last set starts packing; busy stays high until the run ends.
// Packing of n glyphs runs ranking (one width memory read per compare), then
// finds the start line count, then runs each attempt with L lines (one line
// load read per candidate line), then result output. The width and line load
// memories are read one entry a cycle.
// Results appear on result with result_valid high for exactly one cycle:
// one per glyph in load order, then a summary with last_result set. The
// receiver cannot stall; every result is taken the cycle it is shown.
// Reset empties the loaded set and loads the register defaults; memories
// are not cleared. Registers are written through cfg_write; the user must
// do so only while idle, as the block itself does not enforce it.
module glyph_line_packer
  import glp_pkg::*;
#(
  parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  glp_in_t     in_item,
  output logic        result_valid,
  output glp_out_t    result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int IDX_W  = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
  localparam int CNT_W  = $clog2(MAX_LETTERS + 1);
  localparam int LOAD_W = 17 + CNT_W;
  localparam int ACC_W  = 20 + CNT_W;
  localparam int RND_W  = ((LOAD_W > 20) ? LOAD_W : 20) + 1;

  glp_state_t state, state_next;

  logic [3:0]        mip_levels;
  logic [19:0]       line_limit;
  logic [CNT_W-1:0]  cnt;
  logic [LOAD_W-1:0] total;
  logic [CNT_W-1:0]  i_idx, j_idx, jd, rank, lines, b_idx, bd;
  logic [15:0]       wi, wg;
  logic [ACC_W-1:0]  acc;
  logic [IDX_W-1:0]  g, best;
  logic [LOAD_W-1:0] best_load, longest, new_load;
  logic              sv;

  // Memory ports.
  logic              w_we, so_we, ll_we, al_we;
  logic [IDX_W-1:0]  w_waddr, w_raddr, so_waddr, so_raddr;
  logic [IDX_W-1:0]  ll_waddr, ll_raddr, al_waddr, al_raddr;
  logic [15:0]       w_rdata;
  logic [IDX_W-1:0]  so_wdata, so_rdata, al_wdata, al_rdata;
  logic [LOAD_W-1:0] ll_wdata, ll_rdata;

  logic              accept;
  logic [19:0]       mask, limit;
  logic [RND_W-1:0]  longest_ext, mask_ext, rounded, limit_ext;
  logic              too_long, scan_done, rank_hit;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Aligned limit and rounded longest line.
  assign mask        = (20'd1 << mip_levels) - 20'd1;
  assign limit       = line_limit & ~mask;
  assign longest_ext = RND_W'(longest);
  assign mask_ext    = RND_W'(mask);
  assign limit_ext   = RND_W'(limit);
  assign rounded     = (longest_ext + mask_ext) & ~mask_ext;
  assign too_long    = longest_ext > limit_ext;
  assign new_load    = best_load + LOAD_W'(wg) + LOAD_W'(3);
  assign rank_hit    = (w_rdata > wi) || ((w_rdata == wi) && (jd > i_idx));

  // A scan is done once its counter reached the end and the last read drained.
  always_comb begin
    scan_done = 1'b0;
    if (state == S_RANK_SCAN) begin
      scan_done = (j_idx == cnt) && !sv;
    end else if (state == S_SCAN) begin
      scan_done = (b_idx == lines) && !sv;
    end else if (state == S_EMIT) begin
      scan_done = (i_idx == cnt) && !sv;
    end
  end

  glp_ram #(.WIDTH(16), .DEPTH(MAX_LETTERS)) u_width (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_item.glyph_width),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  glp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LETTERS)) u_order (
    .clk(clk), .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
    .raddr(so_raddr), .rdata(so_rdata)
  );

  glp_ram #(.WIDTH(LOAD_W), .DEPTH(MAX_LETTERS)) u_load (
    .clk(clk), .we(ll_we), .waddr(ll_waddr), .wdata(ll_wdata),
    .raddr(ll_raddr), .rdata(ll_rdata)
  );

  glp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LETTERS)) u_assign (
    .clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
    .raddr(al_raddr), .rdata(al_rdata)
  );

  // Next state and memory control.
  always_comb begin
    state_next = state;
    w_we     = 1'b0;
    w_waddr  = cnt[IDX_W-1:0];
    w_raddr  = i_idx[IDX_W-1:0];
    so_we    = 1'b0;
    so_waddr = rank[IDX_W-1:0];
    so_wdata = i_idx[IDX_W-1:0];
    so_raddr = i_idx[IDX_W-1:0];
    ll_we    = 1'b0;
    ll_waddr = b_idx[IDX_W-1:0];
    ll_wdata = LOAD_W'(1);
    ll_raddr = b_idx[IDX_W-1:0];
    al_we    = 1'b0;
    al_waddr = g;
    al_wdata = best;
    al_raddr = i_idx[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept && in_item.command == CMD_LOAD) begin
          w_we = (cnt < CNT_W'(MAX_LETTERS));
          if (in_item.last) begin
            state_next = S_RANK_A;
          end
        end
      end
      S_RANK_A: begin
        state_next = (i_idx == cnt) ? S_LINES : S_RANK_B;
      end
      S_RANK_B: begin
        state_next = S_RANK_SCAN;
      end
      S_RANK_SCAN: begin
        w_raddr = j_idx[IDX_W-1:0];
        if (scan_done) begin
          so_we      = 1'b1;
          state_next = S_RANK_A;
        end
      end
      S_LINES: begin
        if (acc >= ACC_W'(total) || lines >= cnt) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        ll_we = 1'b1;
        if (b_idx == lines - CNT_W'(1)) begin
          state_next = S_PICK_A;
        end
      end
      S_PICK_A: begin
        state_next = (i_idx == cnt) ? S_CHECK : S_PICK_B;
      end
      S_PICK_B: begin
        w_raddr    = so_rdata;
        state_next = S_PICK_C;
      end
      S_PICK_C: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        ll_we      = 1'b1;
        ll_waddr   = best;
        ll_wdata   = new_load;
        al_we      = 1'b1;
        state_next = S_PICK_A;
      end
      S_CHECK: begin
        state_next = (too_long && lines < cnt) ? S_INIT : S_EMIT;
      end
      S_EMIT: begin
        if (scan_done) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mip_levels <= MIP_LEVELS_RESET;
      line_limit <= LINE_LIMIT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_MIP_LEVELS) begin
        mip_levels <= cfg_data[3:0];
      end else if (cfg_index == CFG_LINE_LIMIT) begin
        line_limit <= cfg_data;
      end
    end
  end

  // Loaded set bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      total <= LOAD_W'(1);
    end else if (state == S_SUM) begin
      cnt   <= '0;
      total <= LOAD_W'(1);
    end else if (accept) begin
      if (in_item.command == CMD_CLEAR) begin
        cnt   <= '0;
        total <= LOAD_W'(1);
      end else if (cnt < CNT_W'(MAX_LETTERS)) begin
        cnt   <= cnt + CNT_W'(1);
        total <= total + LOAD_W'(in_item.glyph_width) + LOAD_W'(3);
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ((state == S_EMIT) && sv) || (state == S_SUM);
    end
  end

  // Sort, packing and output datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        i_idx <= '0;
      end
      S_RANK_A: begin
        lines <= CNT_W'(1);
        acc   <= ACC_W'(limit);
      end
      S_RANK_B: begin
        wi    <= w_rdata;
        j_idx <= '0;
        rank  <= '0;
        sv    <= 1'b0;
      end
      S_RANK_SCAN: begin
        if (j_idx < cnt) begin
          j_idx <= j_idx + CNT_W'(1);
        end
        sv <= (j_idx < cnt);
        jd <= j_idx;
        if (sv && rank_hit) begin
          rank <= rank + CNT_W'(1);
        end
        if (scan_done) begin
          i_idx <= i_idx + CNT_W'(1);
        end
      end
      S_LINES: begin
        b_idx <= '0;
        if (!(acc >= ACC_W'(total) || lines >= cnt)) begin
          lines <= lines + CNT_W'(1);
          acc   <= acc + ACC_W'(limit);
        end
      end
      S_INIT: begin
        b_idx   <= b_idx + CNT_W'(1);
        i_idx   <= '0;
        longest <= '0;
      end
      S_PICK_A: begin
        sv <= 1'b0;
      end
      S_PICK_B: begin
        g <= so_rdata;
      end
      S_PICK_C: begin
        wg    <= w_rdata;
        b_idx <= '0;
        sv    <= 1'b0;
      end
      S_SCAN: begin
        if (b_idx < lines) begin
          b_idx <= b_idx + CNT_W'(1);
        end
        sv <= (b_idx < lines);
        bd <= b_idx;
        if (sv && (bd == '0 || ll_rdata < best_load)) begin
          best      <= bd[IDX_W-1:0];
          best_load <= ll_rdata;
        end
      end
      S_UPD: begin
        if (new_load > longest) begin
          longest <= new_load;
        end
        i_idx <= i_idx + CNT_W'(1);
      end
      S_CHECK: begin
        b_idx <= '0;
        sv    <= 1'b0;
        if (too_long && lines < cnt) begin
          lines <= lines + CNT_W'(1);
        end else begin
          i_idx <= '0;
        end
      end
      S_EMIT: begin
        if (i_idx < cnt) begin
          i_idx <= i_idx + CNT_W'(1);
        end
        sv <= (i_idx < cnt);
        jd <= i_idx;
        if (sv) begin
          result.is_summary     <= 1'b0;
          result.glyph_index    <= 5'(jd);
          result.line_index     <= 5'(al_rdata);
          result.line_count     <= '0;
          result.max_line_width <= '0;
          result.overflow       <= 1'b0;
          result.last_result    <= 1'b0;
        end
      end
      S_SUM: begin
        result.is_summary     <= 1'b1;
        result.glyph_index    <= '0;
        result.line_index     <= '0;
        result.line_count     <= 6'(lines);
        result.max_line_width <= rounded[19:0];
        result.overflow       <= too_long;
        result.last_result    <= 1'b1;
      end
      default: begin
        sv <= 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/glp_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module glp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
